// ----- rtl/pan_tilt_tracking_controller_top_macros.svh -----
// assertion macros for the pan/tilt tracking controller
`ifndef PAN_TILT_TRACKING_CONTROLLER_TOP_MACROS_SVH
`define PAN_TILT_TRACKING_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PTTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pttc_pkg.sv -----
// shared types and constants of the pan/tilt tracking controller
package pttc_pkg;

    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned POS_W       = 11;
    localparam int unsigned TX_W        = 9;
    localparam int unsigned TY_W        = 8;
    localparam int unsigned AREA_W      = 32;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 80;
    localparam int unsigned M_TDATA_W   = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_AREA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETREAT    = 3'd4;

    // register reset values
    localparam logic [TX_W-1:0]          TARGET_X_RST  = 9'd160;
    localparam logic [TY_W-1:0]          TARGET_Y_RST  = 8'd100;
    localparam logic [AREA_W-1:0]        TARGET_AREA_RST = 32'd2000;
    localparam logic signed [AREA_W-1:0] APPROACH_RST  = 32'sd500;
    localparam logic signed [AREA_W-1:0] RETREAT_RST   = -32'sd500;

    localparam logic [FIELD_W-1:0] VALID_SIG = 16'd1;
    localparam logic [FIELD_W-1:0] X_LIMIT   = 16'd319;

    localparam logic [POS_W-1:0] PAN_MIN    = 11'd250;
    localparam logic [POS_W-1:0] PAN_MAX    = 11'd1250;
    localparam logic [POS_W-1:0] TILT_MIN   = 11'd630;
    localparam logic [POS_W-1:0] TILT_MAX   = 11'd1100;
    localparam logic [POS_W-1:0] PAN_CENTRE = 11'd750;
    localparam logic [POS_W-1:0] TILT_RST   = 11'd750;
    localparam logic [POS_W-1:0] STEER_HI   = 11'd800;  // centre plus steer band
    localparam logic [POS_W-1:0] STEER_LO   = 11'd700;  // centre minus steer band

    localparam int DX_WINDOW = 30;
    localparam int DY_WINDOW = 5;

    typedef enum logic [1:0] {
        DRIVE_NONE  = 2'd0,
        DRIVE_STOP  = 2'd1,
        DRIVE_MOVE0 = 2'd2,
        DRIVE_MOVE1 = 2'd3
    } drive_t;

    typedef enum logic {
        DIR_LEFT  = 1'b0,
        DIR_RIGHT = 1'b1
    } dir_t;

    // precomputed step handed from the calc stage to the tracking stage
    typedef struct packed {
        logic               tracked;    // signature ok and column in range
        logic               far;        // outside the centre window
        logic signed [7:0]  pan_step;   // ceil(dx / 6)
        logic signed [15:0] tilt_step;  // floor(5 * dy / 18)
        drive_t             drive;      // drive code for the near case
    } calc_t;

endpackage

// ----- rtl/pttc_calc.sv -----
// calc stage: offsets, scaled steps, area excess and drive decision
module pttc_calc (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pttc_pkg::FIELD_W-1:0]          signature,
    input  logic [pttc_pkg::FIELD_W-1:0]          pos_x,
    input  logic [pttc_pkg::FIELD_W-1:0]          pos_y,
    input  logic [pttc_pkg::FIELD_W-1:0]          obj_width,
    input  logic [pttc_pkg::FIELD_W-1:0]          obj_height,
    input  logic [pttc_pkg::TX_W-1:0]             target_x,
    input  logic [pttc_pkg::TY_W-1:0]             target_y,
    input  logic [pttc_pkg::AREA_W-1:0]           target_area,
    input  logic signed [pttc_pkg::AREA_W-1:0]    approach_threshold,
    input  logic signed [pttc_pkg::AREA_W-1:0]    retreat_threshold,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pttc_pkg::calc_t                       out_calc
);

    logic               valid_reg, valid_next;
    pttc_pkg::calc_t    calc_reg, calc_next;

    logic signed [16:0] dx, dy;
    logic [9:0]         pan_off;
    logic [25:0]        pan_prod;
    logic [7:0]         pan_floor;
    logic [18:0]        py5, tilt_off;
    logic [10:0]        ty5;
    logic [38:0]        tilt_prod;
    logic [14:0]        tilt_floor;
    logic [31:0]        area;
    logic signed [32:0] excess;
    logic               approach, retreat;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dx = $signed({1'b0, pos_x}) - $signed({8'd0, target_x});
        dy = $signed({1'b0, pos_y}) - $signed({9'd0, target_y});

        // ceil(dx/6) = floor((dx + 5)/6); offset by 6*86 to stay non-negative
        pan_off   = dx[9:0] + 10'd521;
        pan_prod  = {16'd0, pan_off} * 26'd43691;
        pan_floor = pan_prod[25:18];

        // floor(5*dy/18), offset by 18*72 to stay non-negative
        py5        = {1'b0, pos_y, 2'b00} + {3'd0, pos_y};
        ty5        = {1'b0, target_y, 2'b00} + {3'd0, target_y};
        tilt_off   = py5 + 19'd1296 - {8'd0, ty5};
        tilt_prod  = {20'd0, tilt_off} * 39'd932068;
        tilt_floor = tilt_prod[38:24];

        area     = {16'd0, obj_width} * {16'd0, obj_height};
        excess   = $signed({1'b0, area}) - $signed({1'b0, target_area});
        approach = excess > $signed({approach_threshold[31], approach_threshold});
        retreat  = excess < $signed({retreat_threshold[31], retreat_threshold});

        calc_next.tracked   = (signature == pttc_pkg::VALID_SIG) && (pos_x < pttc_pkg::X_LIMIT);
        calc_next.far       = (dx > 17'(pttc_pkg::DX_WINDOW)) || (dx < -17'(pttc_pkg::DX_WINDOW))
                           || (dy > 17'(pttc_pkg::DY_WINDOW)) || (dy < -17'(pttc_pkg::DY_WINDOW));
        calc_next.pan_step  = $signed(pan_floor - 8'd86);
        calc_next.tilt_step = $signed({1'b0, tilt_floor} - 16'd72);
        if (approach) begin
            calc_next.drive = pttc_pkg::DRIVE_MOVE0;
        end else if (retreat) begin
            calc_next.drive = pttc_pkg::DRIVE_MOVE1;
        end else begin
            calc_next.drive = pttc_pkg::DRIVE_STOP;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            calc_reg <= calc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_calc  = calc_reg;

endmodule

// ----- rtl/pttc_track.sv -----
// tracking stage: pan/tilt state, steer direction and result register
module pttc_track (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pttc_pkg::calc_t                   in_calc,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              servo_write,
    output logic [pttc_pkg::POS_W-1:0]        pan_pos,
    output logic [pttc_pkg::POS_W-1:0]        tilt_pos,
    output logic                              steer_on,
    output logic                              steer_dir,
    output logic [1:0]                        drive_cmd
);

    logic [pttc_pkg::POS_W-1:0] pan_reg, pan_next, tilt_reg, tilt_next;
    pttc_pkg::dir_t             dir_reg, dir_next;
    logic                       valid_reg, valid_next;
    logic                       servo_reg, servo_next, steer_reg, steer_next;
    pttc_pkg::drive_t           drive_reg, drive_next;
    logic signed [12:0]         pan_sum, pan_clamped;
    logic signed [17:0]         tilt_sum, tilt_clamped;
    logic                       take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb begin
        pan_sum  = $signed({2'b00, pan_reg}) - $signed({{5{in_calc.pan_step[7]}}, in_calc.pan_step});
        tilt_sum = $signed({7'd0, tilt_reg})
                 + $signed({{2{in_calc.tilt_step[15]}}, in_calc.tilt_step});

        if (pan_sum < $signed({2'b00, pttc_pkg::PAN_MIN})) begin
            pan_clamped = $signed({2'b00, pttc_pkg::PAN_MIN});
        end else if (pan_sum > $signed({2'b00, pttc_pkg::PAN_MAX})) begin
            pan_clamped = $signed({2'b00, pttc_pkg::PAN_MAX});
        end else begin
            pan_clamped = pan_sum;
        end
        if (tilt_sum < $signed({7'd0, pttc_pkg::TILT_MIN})) begin
            tilt_clamped = $signed({7'd0, pttc_pkg::TILT_MIN});
        end else if (tilt_sum > $signed({7'd0, pttc_pkg::TILT_MAX})) begin
            tilt_clamped = $signed({7'd0, pttc_pkg::TILT_MAX});
        end else begin
            tilt_clamped = tilt_sum;
        end

        pan_next   = pan_reg;
        tilt_next  = tilt_reg;
        dir_next   = dir_reg;
        servo_next = 1'b0;
        steer_next = 1'b0;
        drive_next = pttc_pkg::DRIVE_STOP;

        if (in_calc.tracked) begin
            pan_next  = pan_clamped[10:0];
            tilt_next = tilt_clamped[10:0];
            if (in_calc.far) begin
                servo_next = 1'b1;
                drive_next = pttc_pkg::DRIVE_NONE;
            end else begin
                if (pan_next > pttc_pkg::PAN_CENTRE) begin
                    dir_next = pttc_pkg::DIR_LEFT;
                end else if (pan_next < pttc_pkg::PAN_CENTRE) begin
                    dir_next = pttc_pkg::DIR_RIGHT;
                end
                steer_next = (pan_next > pttc_pkg::STEER_HI) || (pan_next < pttc_pkg::STEER_LO);
                drive_next = in_calc.drive;
            end
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pan_reg   <= pttc_pkg::PAN_CENTRE;
            tilt_reg  <= pttc_pkg::TILT_RST;
            dir_reg   <= pttc_pkg::DIR_LEFT;
        end else begin
            valid_reg <= valid_next;
            if (take) begin
                pan_reg  <= pan_next;
                tilt_reg <= tilt_next;
                dir_reg  <= dir_next;
            end
        end
        if (take) begin
            servo_reg <= servo_next;
            steer_reg <= steer_next;
            drive_reg <= drive_next;
        end
    end

    assign out_valid   = valid_reg;
    assign servo_write = servo_reg;
    assign pan_pos     = pan_reg;
    assign tilt_pos    = tilt_reg;
    assign steer_on    = steer_reg;
    assign steer_dir   = dir_reg;
    assign drive_cmd   = drive_reg;

endmodule

// ----- rtl/pan_tilt_tracking_controller_top.sv -----
// top level of the pan/tilt tracking controller
// usage:
//   s_ channel takes one object report word (signature, x, y, width, height)
//   m_ channel returns exactly one result word per report, in order
//   cfg_wr_en/cfg_index/cfg_wdata write the target point, target area and
//   the two drive thresholds; write only while no report is in flight
// latency: a report accepted at one edge shows its result on m_tvalid two
//   edges later (input register, calc register, tracking/result register)
// throughput: one report per cycle; the pan/tilt feedback closes inside the
//   tracking stage in one cycle, since the divide-by-constant steps are
//   worked out one stage earlier and do not depend on the state
// reset (aresetn low, synchronous): pipeline emptied, pan and tilt go to
//   750, steer direction to left, registers to their defaults
// stall: when m_tready is low the result word holds; each stage still fills
//   while it is empty, so up to three words sit in the pipe before s_tready
//   drops
module pan_tilt_tracking_controller_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // report input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // signature[15:0], pos_x[31:16], pos_y[47:32], obj_width[63:48], obj_height[79:64]
    input  logic [pttc_pkg::S_TDATA_W-1:0]       s_tdata,
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // servo_write[0], pan_pos[11:1], tilt_pos[22:12], steer_on[23], steer_dir[24],
    // drive_cmd[26:25], zero[31:27]
    output logic [pttc_pkg::M_TDATA_W-1:0]       m_tdata,
    // register writes
    input  logic                                 cfg_wr_en,
    input  logic [pttc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pttc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // configuration registers
    logic [pttc_pkg::TX_W-1:0]          target_x_reg;
    logic [pttc_pkg::TY_W-1:0]          target_y_reg;
    logic [pttc_pkg::AREA_W-1:0]        target_area_reg;
    logic signed [pttc_pkg::AREA_W-1:0] approach_reg;
    logic signed [pttc_pkg::AREA_W-1:0] retreat_reg;

    // input register
    logic                               in_valid_reg;
    logic [pttc_pkg::S_TDATA_W-1:0]     in_data_reg;
    logic                               calc_ready;

    // calc to tracking stage
    logic                               calc_valid;
    pttc_pkg::calc_t                    calc_word;
    logic                               track_ready;

    // result fields
    logic                               servo_write;
    logic [pttc_pkg::POS_W-1:0]         pan_pos, tilt_pos;
    logic                               steer_on, steer_dir;
    logic [1:0]                         drive_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg    <= pttc_pkg::TARGET_X_RST;
            target_y_reg    <= pttc_pkg::TARGET_Y_RST;
            target_area_reg <= pttc_pkg::TARGET_AREA_RST;
            approach_reg    <= pttc_pkg::APPROACH_RST;
            retreat_reg     <= pttc_pkg::RETREAT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pttc_pkg::REG_TARGET_X:    target_x_reg    <= cfg_wdata[pttc_pkg::TX_W-1:0];
                pttc_pkg::REG_TARGET_Y:    target_y_reg    <= cfg_wdata[pttc_pkg::TY_W-1:0];
                pttc_pkg::REG_TARGET_AREA: target_area_reg <= cfg_wdata;
                pttc_pkg::REG_APPROACH:    approach_reg    <= $signed(cfg_wdata);
                pttc_pkg::REG_RETREAT:     retreat_reg     <= $signed(cfg_wdata);
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // input register: fills whenever empty or moving on, held off in reset
    assign s_tready = aresetn && (!in_valid_reg || calc_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    pttc_calc u_calc (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (in_valid_reg),
        .in_ready           (calc_ready),
        .signature          (in_data_reg[15:0]),
        .pos_x              (in_data_reg[31:16]),
        .pos_y              (in_data_reg[47:32]),
        .obj_width          (in_data_reg[63:48]),
        .obj_height         (in_data_reg[79:64]),
        .target_x           (target_x_reg),
        .target_y           (target_y_reg),
        .target_area        (target_area_reg),
        .approach_threshold (approach_reg),
        .retreat_threshold  (retreat_reg),
        .out_valid          (calc_valid),
        .out_ready          (track_ready),
        .out_calc           (calc_word)
    );

    // pan/tilt state lives here; it advances only when a word enters the result register
    pttc_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (calc_valid),
        .in_ready    (track_ready),
        .in_calc     (calc_word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .servo_write (servo_write),
        .pan_pos     (pan_pos),
        .tilt_pos    (tilt_pos),
        .steer_on    (steer_on),
        .steer_dir   (steer_dir),
        .drive_cmd   (drive_cmd)
    );

    assign m_tdata = {5'd0, drive_cmd, steer_dir, steer_on, tilt_pos, pan_pos, servo_write};

    `include "pan_tilt_tracking_controller_top_macros.svh"

    // pan always inside its clamp range
    `PTTC_ASSERT_SAME(a_pan_range, m_tvalid, (pan_pos >= pttc_pkg::PAN_MIN) && (pan_pos <= pttc_pkg::PAN_MAX), "pan out of range")
    // tilt always inside its clamp range
    `PTTC_ASSERT_SAME(a_tilt_range, m_tvalid, (tilt_pos >= pttc_pkg::TILT_MIN) && (tilt_pos <= pttc_pkg::TILT_MAX), "tilt out of range")
    // a servo write never carries a drive or steer command
    `PTTC_ASSERT_SAME(a_servo_only, m_tvalid && servo_write, (drive_cmd == pttc_pkg::DRIVE_NONE) && !steer_on, "servo write with drive")
    // steering only comes with a drive decision
    `PTTC_ASSERT_SAME(a_steer_drive, m_tvalid && steer_on, (drive_cmd != pttc_pkg::DRIVE_NONE) && !servo_write, "steer without drive")

endmodule
